// ===== src/gba_pkg.sv =====
// shared types and constants for the growing bump arena allocator
package gba_pkg;

   localparam int CMD_W     = 2;
   localparam int SIZE_W    = 32;
   localparam int ALIGN_W   = 32;
   localparam int CFG_W     = 33;
   localparam int CSR_IDX_W = 2;
   localparam int STATUS_W  = 3;
   localparam int BIDX_W    = 4;
   localparam int OFF_W     = 33;
   localparam int TAB_W     = 34;

   // command codes
   localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESET_OFFS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_NULL      = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_ALIGN = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SIZE     = 2'd1;

   localparam logic [CFG_W-1:0] MAX_SIZE_RST = 33'd65536;

   typedef enum logic [1:0] {
      RSP_PLAIN,
      RSP_GRANT,
      RSP_APPEND
   } gba_rsp_kind_type;

   // controller to datapath
   typedef struct packed {
      logic                load_req;
      logic                calc_align;
      logic                grant;
      logic                cap_step;
      logic                append;
      logic                do_clear;
      logic                sweep_start;
      logic                sweep_step;
      logic                rst_offs_done;
      logic                respond;
      gba_rsp_kind_type    rsp_kind;
      logic [STATUS_W-1:0] rsp_status;
   } gba_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic size_zero;
      logic align_bad;
      logic cur_valid;
      logic table_full;
      logic fits;
      logic sweep_last;
      logic empty;
   } gba_stat_type;

endpackage

// ===== src/growing_bump_arena_allocator_unit.sv =====
// growing bump arena allocator: one request at a time, strobe on rsp_valid
// allocate: strobe after the check state on null, bad alignment or exhausted with no current
//   block; after fit on a grant or exhausted after a miss in the current block; on an append
//   after cap1 and cap2; reset offsets: one offset table entry zeroed per cycle in the sweep;
//   clear and unused commands answer from idle; the next request is taken in the strobe cycle
// synchronous reset: no blocks, default initial and max sizes; tables are not cleared
module growing_bump_arena_allocator_unit #(
   parameter int              MAX_BLOCKS      = 16,
   parameter longint unsigned DEFAULT_INITIAL = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [gba_pkg::CMD_W-1:0]        req_command,
   input  logic [gba_pkg::SIZE_W-1:0]       req_size,
   input  logic [gba_pkg::ALIGN_W-1:0]      req_align,
   output logic                             rsp_valid,
   output logic [gba_pkg::STATUS_W-1:0]     rsp_status,
   output logic [gba_pkg::BIDX_W-1:0]       rsp_block_index,
   output logic [gba_pkg::OFF_W-1:0]        rsp_grant_offset,
   output logic                             rsp_new_block,
   output logic [gba_pkg::OFF_W-1:0]        rsp_new_capacity,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gba_pkg::CFG_W-1:0]        csr_wdata
);

   gba_pkg::gba_cmd_type  cmd;
   gba_pkg::gba_stat_type stat;

   assign csr_ready = 1'b1;

   gba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   gba_dp #(
      .MAX_BLOCKS      (MAX_BLOCKS),
      .DEFAULT_INITIAL (DEFAULT_INITIAL)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_size         (req_size),
      .req_align        (req_align),
      .csr_we           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_status       (rsp_status),
      .rsp_block_index  (rsp_block_index),
      .rsp_grant_offset (rsp_grant_offset),
      .rsp_new_block    (rsp_new_block),
      .rsp_new_capacity (rsp_new_capacity)
   );

endmodule

// ===== src/gba_ram.sv =====
// generic single write port ram with registered read
module gba_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gba_ctrl.sv =====
// controller state machine sequencing allocate, sweep and clear commands
module gba_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [gba_pkg::CMD_W-1:0]    req_command,
   input  gba_pkg::gba_stat_type        stat,
   output gba_pkg::gba_cmd_type         cmd,
   output logic                         busy,
   output logic                         rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FIT,
      ST_CAP1,
      ST_CAP2,
      ST_SWEEP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      cmd.rsp_kind = gba_pkg::RSP_PLAIN;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               case (req_command)
                  gba_pkg::CMD_ALLOC: begin
                     state_in = ST_CHECK;
                  end
                  gba_pkg::CMD_RESET_OFFS: begin
                     if (stat.empty) begin
                        cmd.rst_offs_done = 1'b1;
                        cmd.respond       = 1'b1;
                        cmd.rsp_status    = gba_pkg::STAT_DONE;
                     end else begin
                        cmd.sweep_start = 1'b1;
                        state_in        = ST_SWEEP;
                     end
                  end
                  gba_pkg::CMD_CLEAR: begin
                     cmd.do_clear   = 1'b1;
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = gba_pkg::STAT_DONE;
                  end
                  default: begin
                     cmd.respond    = 1'b1;
                     cmd.rsp_status = gba_pkg::STAT_DONE;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            cmd.calc_align = 1'b1;
            if (stat.size_zero) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = gba_pkg::STAT_NULL;
            end else if (stat.align_bad) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = gba_pkg::STAT_BAD_ALIGN;
            end else if (stat.cur_valid) begin
               state_in = ST_FIT;
            end else if (stat.table_full) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = gba_pkg::STAT_EXHAUSTED;
            end else begin
               state_in = ST_CAP1;
            end
         end
         ST_FIT: begin
            if (stat.fits) begin
               cmd.grant      = 1'b1;
               cmd.respond    = 1'b1;
               cmd.rsp_kind   = gba_pkg::RSP_GRANT;
               cmd.rsp_status = gba_pkg::STAT_OK;
            end else if (stat.table_full) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = gba_pkg::STAT_EXHAUSTED;
            end else begin
               state_in = ST_CAP1;
            end
         end
         ST_CAP1: begin
            cmd.cap_step = 1'b1;
            state_in     = ST_CAP2;
         end
         ST_CAP2: begin
            cmd.append     = 1'b1;
            cmd.respond    = 1'b1;
            cmd.rsp_kind   = gba_pkg::RSP_APPEND;
            cmd.rsp_status = gba_pkg::STAT_OK;
         end
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               cmd.rst_offs_done = 1'b1;
               cmd.respond       = 1'b1;
               cmd.rsp_status    = gba_pkg::STAT_DONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         state_in     = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/gba_dp.sv =====
// datapath: config registers, block tables, bump arithmetic and result registers
module gba_dp #(
   parameter int              MAX_BLOCKS      = 16,
   parameter longint unsigned DEFAULT_INITIAL = 4096
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [gba_pkg::SIZE_W-1:0]      req_size,
   input  logic [gba_pkg::ALIGN_W-1:0]     req_align,
   input  logic                            csr_we,
   input  logic [gba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gba_pkg::CFG_W-1:0]       csr_wdata,
   input  gba_pkg::gba_cmd_type            cmd,
   output gba_pkg::gba_stat_type           stat,
   output logic [gba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [gba_pkg::BIDX_W-1:0]      rsp_block_index,
   output logic [gba_pkg::OFF_W-1:0]       rsp_grant_offset,
   output logic                            rsp_new_block,
   output logic [gba_pkg::OFF_W-1:0]       rsp_new_capacity
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int BU_W  = $clog2(MAX_BLOCKS + 1);
   localparam int CW    = gba_pkg::CFG_W;
   localparam int TW    = gba_pkg::TAB_W;
   localparam int SW    = gba_pkg::SIZE_W;
   localparam int AW    = gba_pkg::ALIGN_W;

   function automatic logic [CW-1:0] eff_init(input logic [CW-1:0] v);
      eff_init = (v == '0) ? CW'(DEFAULT_INITIAL) : v;
   endfunction

   // control state
   logic [CW-1:0]    init_ff, init_in;
   logic [CW-1:0]    max_ff, max_in;
   logic [TW-1:0]    grow_ff, grow_in;
   logic [BU_W-1:0]  used_ff, used_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;

   // payload
   logic [SW-1:0]                 size_ff;
   logic [AW-1:0]                 align_ff;
   logic [TW:0]                   aligned_ff;
   logic [CW-1:0]                 mincap_ff;
   logic [TW-1:0]                 t1_ff;
   logic [gba_pkg::STATUS_W-1:0]  status_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic [gba_pkg::OFF_W-1:0]     off_ff;
   logic                          nb_ff;
   logic [gba_pkg::OFF_W-1:0]     ncap_ff;

   logic [CW-1:0]    einit, emax;
   logic [AW-1:0]    align_eff, am1;
   logic [TW+1:0]    end_sum;
   logic [TW-1:0]    cap_rd, off_rd;
   logic [TW-1:0]    t_a, cap_lim, cap_new;
   logic [TW:0]      grow_dbl;
   logic [IDX_W-1:0] used_idx;
   logic [IDX_W+3:0] idx_ext;

   logic             off_we, cap_we;
   logic [IDX_W-1:0] off_waddr;
   logic [TW-1:0]    off_wdata;

   assign einit    = eff_init(init_ff);
   assign emax     = (max_ff < einit) ? einit : max_ff;
   assign used_idx = used_ff[IDX_W-1:0];

   assign align_eff = (align_ff == '0) ? AW'(1) : align_ff;
   assign am1       = align_eff - AW'(1);
   assign end_sum   = (TW+2)'(aligned_ff) + (TW+2)'(size_ff);

   // capacity: clamp grow size between initial and max, never below size+align-1
   assign t_a      = (grow_ff > TW'(mincap_ff)) ? grow_ff : TW'(mincap_ff);
   assign cap_lim  = (t1_ff < TW'(emax)) ? t1_ff : TW'(emax);
   assign cap_new  = (cap_lim < TW'(mincap_ff)) ? TW'(mincap_ff) : cap_lim;
   assign grow_dbl = {grow_ff, 1'b0};

   assign stat.size_zero  = (size_ff == '0);
   assign stat.align_bad  = ((align_eff & am1) != '0);
   assign stat.cur_valid  = cur_valid_ff;
   assign stat.table_full = (used_ff >= BU_W'(MAX_BLOCKS));
   assign stat.fits       = (end_sum <= (TW+2)'(cap_rd));
   assign stat.sweep_last = ((BU_W'(cnt_ff) + BU_W'(1)) == used_ff);
   assign stat.empty      = (used_ff == '0);

   always_comb begin
      off_we    = cmd.sweep_step | cmd.grant | cmd.append;
      cap_we    = cmd.append;
      off_waddr = used_idx;
      off_wdata = TW'(size_ff);
      if (cmd.sweep_step) begin
         off_waddr = cnt_ff;
         off_wdata = '0;
      end else if (cmd.grant) begin
         off_waddr = cur_ff;
         off_wdata = end_sum[TW-1:0];
      end
   end

   gba_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_BLOCKS)
   ) u_cap_ram (
      .clock   (clock),
      .wr_en   (cap_we),
      .wr_addr (used_idx),
      .wr_data (cap_new),
      .rd_addr (cur_ff),
      .rd_data (cap_rd)
   );

   gba_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_BLOCKS)
   ) u_off_ram (
      .clock   (clock),
      .wr_en   (off_we),
      .wr_addr (off_waddr),
      .wr_data (off_wdata),
      .rd_addr (cur_ff),
      .rd_data (off_rd)
   );

   always_comb begin
      init_in      = init_ff;
      max_in       = max_ff;
      grow_in      = grow_ff;
      used_in      = used_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      cnt_in       = cnt_ff;
      if (csr_we) begin
         case (csr_index)
            gba_pkg::CSR_INITIAL_SIZE: begin
               init_in = csr_wdata;
               grow_in = TW'(eff_init(csr_wdata));
            end
            gba_pkg::CSR_MAX_SIZE: begin
               max_in  = csr_wdata;
               grow_in = TW'(einit);
            end
            default: begin
            end
         endcase
      end
      if (cmd.do_clear) begin
         used_in      = '0;
         cur_in       = '0;
         cur_valid_in = 1'b0;
         grow_in      = TW'(einit);
      end
      if (cmd.sweep_start) begin
         cnt_in = '0;
      end
      if (cmd.sweep_step) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
      if (cmd.rst_offs_done) begin
         cur_in       = '0;
         cur_valid_in = (used_ff != '0);
      end
      if (cmd.append) begin
         used_in      = used_ff + BU_W'(1);
         cur_in       = used_idx;
         cur_valid_in = 1'b1;
         if (grow_ff < TW'(emax)) begin
            grow_in = (grow_dbl < (TW+1)'(emax)) ? grow_dbl[TW-1:0] : TW'(emax);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         max_ff       <= gba_pkg::MAX_SIZE_RST;
         grow_ff      <= TW'(DEFAULT_INITIAL);
         used_ff      <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         init_ff      <= init_in;
         max_ff       <= max_in;
         grow_ff      <= grow_in;
         used_ff      <= used_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         size_ff  <= req_size;
         align_ff <= req_align;
      end
      if (cmd.calc_align) begin
         aligned_ff <= ((TW+1)'(off_rd) + (TW+1)'(am1)) & ~((TW+1)'(am1));
         mincap_ff  <= CW'(size_ff) + CW'(am1);
      end
      if (cmd.cap_step) begin
         t1_ff <= (t_a > TW'(einit)) ? t_a : TW'(einit);
      end
      if (cmd.respond) begin
         status_ff <= cmd.rsp_status;
         case (cmd.rsp_kind)
            gba_pkg::RSP_GRANT: begin
               idx_ff  <= cur_ff;
               off_ff  <= aligned_ff[gba_pkg::OFF_W-1:0];
               nb_ff   <= 1'b0;
               ncap_ff <= '0;
            end
            gba_pkg::RSP_APPEND: begin
               idx_ff  <= used_idx;
               off_ff  <= '0;
               nb_ff   <= 1'b1;
               ncap_ff <= cap_new[gba_pkg::OFF_W-1:0];
            end
            default: begin
               idx_ff  <= '0;
               off_ff  <= '0;
               nb_ff   <= 1'b0;
               ncap_ff <= '0;
            end
         endcase
      end
   end

   assign idx_ext          = {4'b0, idx_ff};
   assign rsp_status       = status_ff;
   assign rsp_block_index  = idx_ext[gba_pkg::BIDX_W-1:0];
   assign rsp_grant_offset = off_ff;
   assign rsp_new_block    = nb_ff;
   assign rsp_new_capacity = ncap_ff;

endmodule

// ===== src/gba_chk.sv =====
// port-level checker for the allocator, bound to the top level
module gba_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [gba_pkg::STATUS_W-1:0]     rsp_status,
   input logic [gba_pkg::BIDX_W-1:0]       rsp_block_index,
   input logic [gba_pkg::OFF_W-1:0]        rsp_grant_offset,
   input logic                             rsp_new_block,
   input logic [gba_pkg::OFF_W-1:0]        rsp_new_capacity
);

   // a result only comes out while the unit is ready for the next request
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // every accepted request either keeps the unit busy or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request dropped");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= gba_pkg::STAT_DONE))
      else $error("status out of range");

   // non-ok results carry no placement
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != gba_pkg::STAT_OK)) |->
      (rsp_block_index == '0 && rsp_grant_offset == '0 &&
       !rsp_new_block && rsp_new_capacity == '0))
      else $error("placement fields set on a failed request");

   // a fresh block is always granted at its base and is never empty
   a_new_block_base: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_new_block) |->
      (rsp_status == gba_pkg::STAT_OK && rsp_grant_offset == '0 &&
       rsp_new_capacity != '0))
      else $error("new block grant not at offset zero");

endmodule

bind growing_bump_arena_allocator_unit gba_chk u_gba_chk (.*);

// ===== tb/sv/tb_growing_bump_arena_allocator_unit.sv =====
// testbench for the growing bump arena allocator: directed and random requests vs a predictor
`timescale 1ns / 100ps
module tb_growing_bump_arena_allocator_unit;
   import gba_pkg::*;

   localparam int              ARENA_BLOCKS  = 16;
   localparam longint unsigned ARENA_DEFAULT = 4096;
   localparam int unsigned     ITEM_TARGET   = 1400;
   localparam int              REPORT_LIMIT  = 100;
   localparam logic [63:0]     MASK34        = 64'h3_FFFF_FFFF;

   localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BIDX_W-1:0]   block_index;
      logic [OFF_W-1:0]    grant_offset;
      logic                new_block;
      logic [OFF_W-1:0]    new_capacity;
   } arena_result_t;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic                 busy;
   logic [CMD_W-1:0]     req_command = CMD_ALLOC;
   logic [SIZE_W-1:0]    req_size    = '0;
   logic [ALIGN_W-1:0]   req_align   = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [BIDX_W-1:0]    rsp_block_index;
   logic [OFF_W-1:0]     rsp_grant_offset;
   logic                 rsp_new_block;
   logic [OFF_W-1:0]     rsp_new_capacity;
   logic                 csr_valid   = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index   = CSR_INITIAL_SIZE;
   logic [CFG_W-1:0]     csr_wdata   = '0;

   // predictor state
   bit [63:0]   cap_tab [ARENA_BLOCKS];
   bit [63:0]   off_tab [ARENA_BLOCKS];
   int unsigned used_blocks = 0;
   int unsigned cur_blk     = 0;
   bit          cur_ok      = 1'b0;
   bit [63:0]   grow_bytes  = ARENA_DEFAULT;
   bit [63:0]   initial_reg = '0;
   bit [63:0]   max_reg     = 64'(MAX_SIZE_RST);

   arena_result_t arena_results_q [$];
   int unsigned   items_sent     = 0;
   int unsigned   mismatch_count = 0;
   bit            no_gaps        = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   growing_bump_arena_allocator_unit #(
      .MAX_BLOCKS      (ARENA_BLOCKS),
      .DEFAULT_INITIAL (ARENA_DEFAULT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_size         (req_size),
      .req_align        (req_align),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_block_index  (rsp_block_index),
      .rsp_grant_offset (rsp_grant_offset),
      .rsp_new_block    (rsp_new_block),
      .rsp_new_capacity (rsp_new_capacity),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   function automatic bit [63:0] first_capacity();
      return (initial_reg == 0) ? ARENA_DEFAULT : initial_reg;
   endfunction

   function automatic bit [63:0] capacity_ceiling();
      bit [63:0] first;
      first = first_capacity();
      return (max_reg < first) ? first : max_reg;
   endfunction

   // bump block b past the aligned offset by size when the request fits
   function automatic bit bump_block(int unsigned b, bit [63:0] size, bit [63:0] align,
                                     output bit [63:0] off);
      bit [63:0] aligned;
      aligned = (off_tab[b] + (align - 1)) & ~(align - 1);
      off = '0;
      if (aligned > cap_tab[b] || size > cap_tab[b] - aligned)
         return 1'b0;
      off_tab[b] = (aligned + size) & MASK34;
      off = aligned;
      return 1'b1;
   endfunction

   function automatic arena_result_t arena_predict(logic [CMD_W-1:0] cmd, bit [63:0] size,
                                                   bit [63:0] align);
      arena_result_t r;
      bit [63:0]     off;
      bit [63:0]     min_cap;
      bit [63:0]     ceiling;
      bit [63:0]     cap;
      int unsigned   i;
      r   = '0;
      off = '0;
      case (cmd)
         CMD_RESET_OFFS: begin
            for (i = 0; i < used_blocks; i++)
               off_tab[i] = '0;
            cur_blk  = 0;
            cur_ok   = (used_blocks > 0);
            r.status = STAT_DONE;
         end
         CMD_CLEAR: begin
            used_blocks = 0;
            cur_blk     = 0;
            cur_ok      = 1'b0;
            grow_bytes  = first_capacity();
            r.status    = STAT_DONE;
         end
         CMD_ALLOC: begin
            if (align == 0)
               align = 1;
            if (size == 0) begin
               r.status = STAT_NULL;
            end else if ((align & (align - 1)) != 0) begin
               r.status = STAT_BAD_ALIGN;
            end else if (cur_ok && bump_block(cur_blk, size, align, off)) begin
               r.status       = STAT_OK;
               r.block_index  = BIDX_W'(cur_blk);
               r.grant_offset = OFF_W'(off);
            end else if (used_blocks >= ARENA_BLOCKS) begin
               r.status = STAT_EXHAUSTED;
            end else begin
               // new block: grow size raised to fit and to the initial size, clamped, then raised to fit again
               min_cap = size + align - 1;
               ceiling = capacity_ceiling();
               cap     = (grow_bytes > min_cap) ? grow_bytes : min_cap;
               if (cap < first_capacity())
                  cap = first_capacity();
               if (cap > ceiling)
                  cap = ceiling;
               if (cap < min_cap)
                  cap = min_cap;
               cap_tab[used_blocks] = cap & MASK34;
               off_tab[used_blocks] = '0;
               cur_blk = used_blocks;
               cur_ok  = 1'b1;
               used_blocks++;
               if (grow_bytes < ceiling)
                  grow_bytes = ((grow_bytes * 2 < ceiling) ? grow_bytes * 2 : ceiling) & MASK34;
               void'(bump_block(cur_blk, size, align, off));
               r.status       = STAT_OK;
               r.block_index  = BIDX_W'(cur_blk);
               r.grant_offset = OFF_W'(off);
               r.new_block    = 1'b1;
               r.new_capacity = OFF_W'(cap);
            end
         end
         default: begin
            r.status = STAT_DONE;
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < REPORT_LIMIT)
         $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_gaps)
         return 0;
      roll = $urandom_range(99);
      if (roll < 55)
         return 0;
      if (roll < 88)
         return $urandom_range(3, 1);
      if (roll < 97)
         return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return '0;
      if (roll < 65)
         return $urandom_range(64, 1);
      if (roll < 88)
         return $urandom_range(4096, 65);
      if (roll < 96)
         return $urandom_range(1 << 20, 4097);
      return $urandom;
   endfunction

   function automatic logic [ALIGN_W-1:0] random_align();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return '0;
      if (roll < 80)
         return 32'd1 << $urandom_range(6);
      if (roll < 92)
         return 32'd1 << $urandom_range(31);
      return $urandom;
   endfunction

   function automatic logic [CFG_W-1:0] random_capacity();
      logic [CFG_W-1:0] picks [8];
      picks = '{33'd0, 33'd1, 33'd16, 33'd64, 33'd4096, 33'd65536, 33'h1_0000_0000, 33'd1000};
      if ($urandom_range(9) < 8)
         return picks[$urandom_range(7)];
      return CFG_W'($urandom_range(1 << 20));
   endfunction

   // start stays high when the next request follows with no gap
   task automatic send_request(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                               logic [ALIGN_W-1:0] align);
      int unsigned gap;
      start       <= 1'b1;
      req_command <= cmd;
      req_size    <= size;
      req_align   <= align;
      do @(posedge clock); while (busy);
      arena_results_q.push_back(arena_predict(cmd, 64'(size), 64'(align)));
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_results();
      start <= 1'b0;
      while (arena_results_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_INITIAL_SIZE) begin
         initial_reg = 64'(data);
         grow_bytes  = first_capacity();
      end else if (idx == CSR_MAX_SIZE) begin
         max_reg    = 64'(data);
         grow_bytes = first_capacity();
      end
      @(posedge clock);
   endtask

   task automatic send_random();
      int unsigned      roll;
      logic [CMD_W-1:0] cmd;
      roll = $urandom_range(99);
      if (roll < 6) begin
         // noise: every field random
         send_request(CMD_W'($urandom), $urandom, $urandom);
      end else begin
         roll = $urandom_range(99);
         if (roll < 86)
            cmd = CMD_ALLOC;
         else if (roll < 93)
            cmd = CMD_RESET_OFFS;
         else if (roll < 98)
            cmd = CMD_CLEAR;
         else
            cmd = CMD_SPARE;
         send_request(cmd, random_size(), random_align());
      end
   endtask

   task automatic test_directed();
      send_request(CMD_ALLOC, 32'd0, 32'd8);
      send_request(CMD_ALLOC, 32'd1, 32'd0);
      send_request(CMD_ALLOC, 32'd5, 32'd3);
      send_request(CMD_ALLOC, 32'd7, 32'hFFFF_FFFF);
      send_request(CMD_ALLOC, 32'd10, 32'd16);
      send_request(CMD_RESET_OFFS, $urandom, $urandom);
      send_request(CMD_ALLOC, 32'd4096, 32'd1);
      send_request(CMD_ALLOC, 32'd1, 32'd1);
      send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'h8000_0000);
      // offset aligns up past 32 bits inside the huge block
      send_request(CMD_ALLOC, 32'd1, 32'h8000_0000);
      send_request(CMD_SPARE, $urandom, $urandom);
      send_request(CMD_CLEAR, $urandom, $urandom);
      send_request(CMD_RESET_OFFS, $urandom, $urandom);
      send_request(CMD_ALLOC, 32'hFFFF_FFFF, 32'd1);
      send_request(CMD_ALLOC, 32'd1, 32'h4000_0000);
      send_request(CMD_CLEAR, $urandom, $urandom);
   endtask

   // tiny blocks so the table fills, then reset offsets and allocate again
   task automatic test_table_full();
      int unsigned n;
      wait_results();
      write_csr(CSR_INITIAL_SIZE, 33'd16);
      write_csr(CSR_MAX_SIZE, 33'd32);
      repeat (3) begin
         n = $urandom_range(24, 17);
         repeat (n)
            send_request(CMD_ALLOC, $urandom_range(100, 20), 32'd1 << $urandom_range(3));
         send_request(CMD_RESET_OFFS, $urandom, $urandom);
         repeat ($urandom_range(6, 2))
            send_request(CMD_ALLOC, $urandom_range(40, 1), 32'd1 << $urandom_range(4));
         send_request(CMD_CLEAR, $urandom, $urandom);
      end
   endtask

   task automatic test_register_extremes();
      logic [CFG_W-1:0] init_vals [6];
      logic [CFG_W-1:0] max_vals [6];
      init_vals = '{33'd0, 33'h1_0000_0000, 33'd1, 33'h1_0000_0000, 33'd0, 33'd16};
      max_vals  = '{33'd0, 33'h1_0000_0000, 33'd0, 33'd0, 33'h1_0000_0000, 33'd64};
      foreach (init_vals[k]) begin
         wait_results();
         write_csr(CSR_MAX_SIZE, max_vals[k]);
         write_csr(CSR_INITIAL_SIZE, init_vals[k]);
         if (k == 2)
            write_csr(CSR_SPARE_A, CFG_W'($urandom));
         if (k == 3)
            write_csr(CSR_SPARE_B, {1'b1, $urandom});
         repeat (40) send_random();
      end
   endtask

   task automatic test_random_phases();
      int unsigned n;
      while (items_sent < ITEM_TARGET) begin
         wait_results();
         if ($urandom_range(3) != 0)
            write_csr(CSR_INITIAL_SIZE, random_capacity());
         if ($urandom_range(3) != 0)
            write_csr(CSR_MAX_SIZE, random_capacity());
         if ($urandom_range(7) == 0)
            write_csr(($urandom_range(1) != 0) ? CSR_SPARE_A : CSR_SPARE_B, CFG_W'($urandom));
         no_gaps = ($urandom_range(4) == 0);
         n = $urandom_range(150, 50);
         repeat (n) begin
            // now and then, hold off until every outstanding request has answered
            if ($urandom_range(49) == 0)
               wait_results();
            send_random();
         end
         no_gaps = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      arena_result_t want;
      if (!reset && rsp_valid) begin
         if (arena_results_q.size() == 0) begin
            report_mismatch($sformatf("response with none pending, status %0d", rsp_status));
         end else begin
            want = arena_results_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_block_index !== want.block_index)
               report_mismatch($sformatf("block_index %0d, want %0d",
                                         rsp_block_index, want.block_index));
            if (rsp_grant_offset !== want.grant_offset)
               report_mismatch($sformatf("grant_offset %h, want %h",
                                         rsp_grant_offset, want.grant_offset));
            if (rsp_new_block !== want.new_block)
               report_mismatch($sformatf("new_block %b, want %b", rsp_new_block, want.new_block));
            if (rsp_new_capacity !== want.new_capacity)
               report_mismatch($sformatf("new_capacity %h, want %h",
                                         rsp_new_capacity, want.new_capacity));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_register_extremes();
      test_random_phases();
      wait_results();
      repeat (30) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
src/gba_pkg.sv
src/gba_ram.sv
src/gba_ctrl.sv
src/gba_dp.sv
src/growing_bump_arena_allocator_unit.sv
src/gba_chk.sv
tb/sv/tb_growing_bump_arena_allocator_unit.sv
